/* sv/jet_pkg.sv */
// shared types, codes and tables of the joystick event translator
`default_nettype none
package jet_pkg;

	// default element counts
	localparam int BUTTON_COUNT_DEF = 16;
	localparam int HAT_COUNT_DEF    = 4;
	localparam int ANALOG_AXES_DEF  = 16;

	// axes that can drive direction keys, two keys per axis
	localparam int DIGITAL_AXES = 8;
	localparam int DIR_KEYS     = 2 * DIGITAL_AXES;

	// events one sample can cause, and the job queue depth
	localparam int JOB_EVENTS = 4;
	localparam int EV_POS_W   = $clog2(JOB_EVENTS);
	localparam int EV_CNT_W   = $clog2(JOB_EVENTS + 1);
	localparam int JOB_DEPTH  = 2;

	// sample commands
	localparam logic [1:0] CMD_BUTTON = 2'd0;
	localparam logic [1:0] CMD_HAT    = 2'd1;
	localparam logic [1:0] CMD_AXIS   = 2'd2;

	// event kinds
	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_ANALOG = 1'b1;

	// key groups
	localparam logic [1:0] GRP_AXIS   = 2'd0;
	localparam logic [1:0] GRP_HAT    = 2'd1;
	localparam logic [1:0] GRP_BUTTON = 2'd2;

	// configuration registers
	localparam int         CFG_INDEX_W     = 1;
	localparam logic [0:0] REG_DEAD_ZONE   = 1'b0;
	localparam logic [0:0] REG_ANALOG_MODE = 1'b1;
	localparam logic [14:0] DEAD_ZONE_RESET = 15'd4915;

	// hat bitmap to keys: count, first and second direction (0 up, 1 right, 2 down, 3 left)
	localparam logic [1:0] HAT_KEY_COUNT [16] = '{
		2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd0,
		2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0
	};
	localparam logic [1:0] HAT_DIR_FIRST [16] = '{
		2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd0,
		2'd3, 2'd0, 2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0
	};
	localparam logic [1:0] HAT_DIR_SECOND [16] = '{
		2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0,
		2'd0, 2'd3, 2'd0, 2'd0, 2'd3, 2'd0, 2'd0, 2'd0
	};

	typedef struct packed {
		logic              [1:0]  command;
		logic              [3:0]  index;
		logic signed       [15:0] sample;
	} item_t;

	typedef struct packed {
		logic                     event_kind;
		logic              [1:0]  key_group;
		logic              [3:0]  key_slot;
		logic                     pressed;
		logic              [3:0]  axis_number;
		logic signed       [15:0] axis_value;
		logic                     last;
	} result_t;

	// one event without its end marker
	typedef struct packed {
		logic                     event_kind;
		logic              [1:0]  key_group;
		logic              [3:0]  key_slot;
		logic                     pressed;
		logic              [3:0]  axis_number;
		logic signed       [15:0] axis_value;
	} ev_t;

	// all events of one sample, in order, and the position of the final one
	typedef struct packed {
		ev_t [JOB_EVENTS-1:0]  ev;
		logic [EV_POS_W-1:0]   last_pos;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	function automatic ev_t key_ev(input logic [1:0] group, input logic [3:0] slot,
			input logic down);
		ev_t e;
		e             = '0;
		e.event_kind  = KIND_KEY;
		e.key_group   = group;
		e.key_slot    = slot;
		e.pressed     = down;
		return e;
	endfunction

	function automatic ev_t analog_ev(input logic [3:0] axis, input logic signed [15:0] value);
		ev_t e;
		e             = '0;
		e.event_kind  = KIND_ANALOG;
		e.axis_number = axis;
		e.axis_value  = value;
		return e;
	endfunction

endpackage
`default_nettype wire

/* sv/joystick_event_translator.sv */
// top level of the joystick event translator
`default_nettype none
// Turns joystick samples (button level, hat bitmap or axis value, one element per
// sample) into key press/release events and analog axis value events. The front end
// holds the element state and the two configuration registers; it takes one sample
// every cycle while the job queue (JOB_DEPTH entries) has room, and the sample's
// state change is in effect for the very next sample. Each sample yields zero to four
// events; they pass through the job queue and the result register and leave
// it one per cycle while result_stall is low, the final one flagged by last.
// The sustained rate is one event per cycle, set by the single result register.
// Samples that cause no event never reach the queue. Configuration writes are
// always taken (cfg_ready is tied high) and are meant to happen while no events
// are pending.
module joystick_event_translator import jet_pkg::*; #(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
	parameter int HAT_COUNT    = HAT_COUNT_DEF,
	parameter int ANALOG_AXES  = ANALOG_AXES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// sample channel
	input  wire logic                   item_valid,
	output      logic                   item_stall,
	input  wire item_t                  item,
	// event channel
	output      logic                   result_valid,
	input  wire logic                   result_stall,
	output      result_t                result,
	// configuration writes: index 0 dead zone, 1 analog mode
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [14:0]            cfg_data
);

	// job handoff between front and back
	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head;
	q_status_t q_status;

	// front: classify the sample, update state, build its event list
	jet_front #(
		.BUTTON_COUNT (BUTTON_COUNT),
		.HAT_COUNT    (HAT_COUNT),
		.ANALOG_AXES  (ANALOG_AXES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.push       (push),
		.push_job   (push_job)
	);

	// queue lets the input keep going while events wait on a stalled output
	jet_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// back: one event per transfer, job popped with its final event
	jet_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

/* sv/jet_front.sv */
// front end: element state, configuration and event list per sample
`default_nettype none
module jet_front import jet_pkg::*; #(
	parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
	parameter int HAT_COUNT    = HAT_COUNT_DEF,
	parameter int ANALOG_AXES  = ANALOG_AXES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output      logic                   item_stall,
	input  wire item_t                  item,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [14:0]            cfg_data,
	input  wire q_status_t              q_status,
	output      logic                   push,
	output      job_t                   push_job
);

	// sample index is 4 bits, so no more than 16 buttons are reachable
	localparam int BTN_N = (BUTTON_COUNT > 16) ? 16 : BUTTON_COUNT;

	logic [14:0]         dead_zone_q;
	logic                analog_mode_q;
	logic [BTN_N-1:0]    button_q;
	logic [3:0]          hat_q    [HAT_COUNT];
	logic [DIR_KEYS-1:0] dir_held_q;
	logic [15:0]         analog_q [ANALOG_AXES];

	logic                btn_hit, btn_held, btn_down;
	logic                hat_hit;
	logic [3:0]          hat_old, hat_new;
	logic                hat_changed;
	logic                ana_hit;
	logic [15:0]         ana_old;
	logic                dig_axis;
	logic                neg_held, pos_held;
	logic signed [16:0]  s17, dz17, mag17;
	logic                want_neg, want_pos, below_dz;
	logic [15:0]         ana_val;
	ev_t                 cand   [JOB_EVENTS];
	logic [JOB_EVENTS-1:0] cand_v;
	logic [EV_CNT_W-1:0] n_ev;
	logic                accept;
	logic                both_held;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;

	// lookups of the addressed element
	always_comb begin
		btn_hit  = 1'b0;
		btn_held = 1'b0;
		for (int i = 0; i < BTN_N; i++) begin
			if (item.index == 4'(i)) begin
				btn_hit  = 1'b1;
				btn_held = button_q[i];
			end
		end
		hat_hit = 1'b0;
		hat_old = '0;
		for (int i = 0; i < HAT_COUNT; i++) begin
			if (item.index == 4'(i)) begin
				hat_hit = 1'b1;
				hat_old = hat_q[i];
			end
		end
		ana_hit = 1'b0;
		ana_old = '0;
		for (int i = 0; i < ANALOG_AXES; i++) begin
			if (item.index == 4'(i)) begin
				ana_hit = 1'b1;
				ana_old = analog_q[i];
			end
		end
	end

	assign btn_down    = item.sample != 16'sd0;
	assign hat_new     = item.sample[3:0];
	assign hat_changed = hat_hit && (hat_new != hat_old);
	assign dig_axis    = item.index < 4'(DIGITAL_AXES);
	assign neg_held    = dir_held_q[{item.index[2:0], 1'b0}];
	assign pos_held    = dir_held_q[{item.index[2:0], 1'b1}];

	// dead zone compares on 17 bits so that -32768 has a magnitude
	assign s17      = {item.sample[15], item.sample};
	assign dz17     = signed'({2'b00, dead_zone_q});
	assign mag17    = item.sample[15] ? -s17 : s17;
	assign below_dz = mag17 < dz17;
	assign want_neg = s17 < -dz17;
	assign want_pos = s17 > dz17;
	assign ana_val  = below_dz ? 16'd0 : item.sample;

	// candidate events in output order
	always_comb begin
		for (int c = 0; c < JOB_EVENTS; c++) begin
			cand[c] = '0;
		end
		cand_v = '0;
		case (item.command)
			CMD_BUTTON: begin
				cand[0]   = key_ev(GRP_BUTTON, item.index, btn_down);
				cand_v[0] = btn_hit && (btn_down != btn_held);
			end
			CMD_HAT: begin
				// release old direction keys, then press new ones
				cand[0]   = key_ev(GRP_HAT, {item.index[1:0], HAT_DIR_FIRST[hat_old]}, 1'b0);
				cand[1]   = key_ev(GRP_HAT, {item.index[1:0], HAT_DIR_SECOND[hat_old]}, 1'b0);
				cand[2]   = key_ev(GRP_HAT, {item.index[1:0], HAT_DIR_FIRST[hat_new]}, 1'b1);
				cand[3]   = key_ev(GRP_HAT, {item.index[1:0], HAT_DIR_SECOND[hat_new]}, 1'b1);
				cand_v[0] = hat_changed && (HAT_KEY_COUNT[hat_old] != 2'd0);
				cand_v[1] = hat_changed && (HAT_KEY_COUNT[hat_old] == 2'd2);
				cand_v[2] = hat_changed && (HAT_KEY_COUNT[hat_new] != 2'd0);
				cand_v[3] = hat_changed && (HAT_KEY_COUNT[hat_new] == 2'd2);
			end
			CMD_AXIS: begin
				if (analog_mode_q) begin
					// drop held direction keys, then report a changed value
					cand[0]   = key_ev(GRP_AXIS, {item.index[2:0], 1'b0}, 1'b0);
					cand[1]   = key_ev(GRP_AXIS, {item.index[2:0], 1'b1}, 1'b0);
					cand[2]   = analog_ev(item.index, ana_val);
					cand_v[0] = dig_axis && neg_held;
					cand_v[1] = dig_axis && pos_held;
					cand_v[2] = ana_hit && (ana_val != ana_old);
				end else begin
					cand[0]   = key_ev(GRP_AXIS, {item.index[2:0], 1'b0}, want_neg);
					cand[1]   = key_ev(GRP_AXIS, {item.index[2:0], 1'b1}, want_pos);
					cand_v[0] = dig_axis && (want_neg != neg_held);
					cand_v[1] = dig_axis && (want_pos != pos_held);
				end
			end
			default: begin
				cand_v = '0;
			end
		endcase
	end

	// pack the valid candidates to the front of the job
	always_comb begin
		push_job = '0;
		n_ev     = '0;
		for (int c = 0; c < JOB_EVENTS; c++) begin
			if (cand_v[c]) begin
				push_job.ev[n_ev[EV_POS_W-1:0]] = cand[c];
				n_ev = n_ev + EV_CNT_W'(1);
			end
		end
		push_job.last_pos = EV_POS_W'(n_ev - EV_CNT_W'(1));
	end

	assign push = accept && (n_ev != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q   <= DEAD_ZONE_RESET;
			analog_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEAD_ZONE:   dead_zone_q   <= cfg_data;
				REG_ANALOG_MODE: analog_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_q   <= '0;
			dir_held_q <= '0;
			for (int i = 0; i < HAT_COUNT; i++) begin
				hat_q[i] <= '0;
			end
			for (int i = 0; i < ANALOG_AXES; i++) begin
				analog_q[i] <= '0;
			end
		end else if (accept) begin
			case (item.command)
				CMD_BUTTON: begin
					for (int i = 0; i < BTN_N; i++) begin
						if (item.index == 4'(i)) button_q[i] <= btn_down;
					end
				end
				CMD_HAT: begin
					for (int i = 0; i < HAT_COUNT; i++) begin
						if (item.index == 4'(i)) hat_q[i] <= hat_new;
					end
				end
				CMD_AXIS: begin
					if (analog_mode_q) begin
						if (dig_axis) begin
							dir_held_q[{item.index[2:0], 1'b0}] <= 1'b0;
							dir_held_q[{item.index[2:0], 1'b1}] <= 1'b0;
						end
						for (int i = 0; i < ANALOG_AXES; i++) begin
							if (item.index == 4'(i)) analog_q[i] <= ana_val;
						end
					end else if (dig_axis) begin
						dir_held_q[{item.index[2:0], 1'b0}] <= want_neg;
						dir_held_q[{item.index[2:0], 1'b1}] <= want_pos;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		both_held = 1'b0;
		for (int a = 0; a < DIGITAL_AXES; a++) begin
			both_held = both_held | (dir_held_q[2*a] & dir_held_q[2*a+1]);
		end
	end

	a_no_axis_both_ways: assert property (@(posedge clk) disable iff (!arst_n)
		!both_held)
		else $error("axis holds both direction keys");

endmodule
`default_nettype wire

/* sv/jet_queue.sv */
// short job queue between front and back end
`default_nettype none
module jet_queue import jet_pkg::*; #(
	parameter int DEPTH = JOB_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire job_t      push_job,
	input  wire logic      pop,
	output      job_t      head,
	output      q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full     = count_q == CNT_W'(DEPTH);
	assign status.nonempty = count_q != '0;
	assign head            = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("job written into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !status.nonempty))
		else $error("job taken from empty queue");

endmodule
`default_nettype wire

/* sv/jet_back.sv */
// back end: steps through a job and drives the result register
`default_nettype none
module jet_back import jet_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_status_t q_status,
	input  wire job_t      head,
	output      logic      pop,
	output      logic      result_valid,
	input  wire logic      result_stall,
	output      result_t   result
);

	logic [EV_POS_W-1:0] pos_q;
	logic                result_valid_q;
	result_t             result_q;
	logic                load;
	logic                is_last;
	ev_t                 cur;

	assign load    = q_status.nonempty && (!result_valid_q || !result_stall);
	assign cur     = head.ev[pos_q];
	assign is_last = pos_q == head.last_pos;
	assign pop     = load && is_last;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.event_kind  <= cur.event_kind;
			result_q.key_group   <= cur.key_group;
			result_q.key_slot    <= cur.key_slot;
			result_q.pressed     <= cur.pressed;
			result_q.axis_number <= cur.axis_number;
			result_q.axis_value  <= cur.axis_value;
			result_q.last        <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= 1'b1;
				pos_q          <= is_last ? '0 : pos_q + EV_POS_W'(1);
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.nonempty |-> pos_q <= head.last_pos)
		else $error("event position beyond end of job");

	a_pos_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!q_status.nonempty |-> pos_q == '0)
		else $error("event position left over with no job");

endmodule
`default_nettype wire

/* sim/joystick_event_translator_tb.sv */
// self-checking testbench of the joystick event translator
`timescale 1ns / 1ps
module joystick_event_translator_tb;
	import jet_pkg::*;

	// command code the block has no use for
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         HOLD_CYCLES = 300;
	localparam int         RANDOM_PER_PHASE = 45;
	// hat bitmaps that form a direction, plus centered
	localparam logic [3:0] HAT_SHAPES [9] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8,
		4'd9, 4'd12};

	// one expected event and the time its sample was taken
	typedef struct {
		result_t ev;
		longint  stamp;
	} expected_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	item_t                  item_bus     = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b1;
	result_t                result_bus;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [14:0]            cfg_data     = '0;

	// samples waiting to be offered, events waiting to come out
	item_t     pending_samples [$];
	expected_t expected_events [$];

	// translator state as predicted
	logic [14:0] cur_dead_zone;
	logic        cur_analog_mode;
	logic [15:0] button_held;
	logic [3:0]  hat_last [4];
	logic [15:0] dir_keys_held;
	logic [15:0] analog_last [16];

	int      mismatch_count = 0;
	int      cycle_count    = 0;
	int      send_gap;
	int      sink_gap;
	int      hold_left;
	int      hold_requests  = 0;
	int      holds_served;
	bit      calm           = 1'b0;
	result_t wanted;

	joystick_event_translator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	function automatic result_t key_event(input logic [1:0] group, input logic [3:0] slot,
			input logic down);
		result_t r;
		r           = '0;
		r.event_kind = KIND_KEY;
		r.key_group  = group;
		r.key_slot   = slot;
		r.pressed    = down;
		return r;
	endfunction

	// keys of a hat bitmap: vertical direction first, then horizontal;
	// opposite bits cancel the whole pattern
	function automatic int hat_dir_list(input logic [3:0] map, output logic [3:0] dirs);
		int n;
		n    = 0;
		dirs = '0;
		if ((map[0] && map[2]) || (map[1] && map[3]))
			return 0;
		if (map[0] || map[2]) begin
			dirs[1:0] = map[0] ? 2'd0 : 2'd2;
			n = 1;
		end
		if (map[1] || map[3]) begin
			if (n == 0)
				dirs[1:0] = map[1] ? 2'd1 : 2'd3;
			else
				dirs[3:2] = map[1] ? 2'd1 : 2'd3;
			n++;
		end
		return n;
	endfunction

	task automatic set_dir_key(ref result_t events [$], input int slot, input logic want);
		if (want != dir_keys_held[slot]) begin
			dir_keys_held[slot] = want;
			events.push_back(key_event(GRP_AXIS, 4'(slot), want));
		end
	endtask

	// works out the events one accepted sample causes and queues them
	task automatic translate_sample(input item_t smp);
		result_t     events [$];
		expected_t   entry;
		logic [3:0]  dirs;
		logic [15:0] level;
		int          n, s, mag, dz;
		s  = $signed(smp.sample);
		dz = int'(cur_dead_zone);
		case (smp.command)
			CMD_BUTTON: begin
				if ((smp.sample != 16'd0) != button_held[smp.index]) begin
					button_held[smp.index] = (smp.sample != 16'd0);
					events.push_back(key_event(GRP_BUTTON, smp.index, button_held[smp.index]));
				end
			end
			CMD_HAT: begin
				if (smp.index < 4 && smp.sample[3:0] != hat_last[smp.index]) begin
					n = hat_dir_list(hat_last[smp.index], dirs);
					for (int j = 0; j < n; j++)
						events.push_back(key_event(GRP_HAT,
							{smp.index[1:0], (j == 0) ? dirs[1:0] : dirs[3:2]}, 1'b0));
					n = hat_dir_list(smp.sample[3:0], dirs);
					for (int j = 0; j < n; j++)
						events.push_back(key_event(GRP_HAT,
							{smp.index[1:0], (j == 0) ? dirs[1:0] : dirs[3:2]}, 1'b1));
					hat_last[smp.index] = smp.sample[3:0];
				end
			end
			CMD_AXIS: begin
				if (cur_analog_mode) begin
					// held direction keys go up before the value is reported
					if (smp.index < 8) begin
						set_dir_key(events, 2 * smp.index, 1'b0);
						set_dir_key(events, 2 * smp.index + 1, 1'b0);
					end
					mag   = (s < 0) ? -s : s;
					level = (mag < dz) ? 16'd0 : smp.sample;
					if (level != analog_last[smp.index]) begin
						analog_last[smp.index] = level;
						events.push_back('0);
						events[events.size() - 1].event_kind  = KIND_ANALOG;
						events[events.size() - 1].axis_number = smp.index;
						events[events.size() - 1].axis_value  = level;
					end
				end else if (smp.index < 8) begin
					set_dir_key(events, 2 * smp.index, s < -dz);
					set_dir_key(events, 2 * smp.index + 1, s > dz);
				end
			end
			default: ;
		endcase
		foreach (events[i]) begin
			entry.ev      = events[i];
			entry.ev.last = (i == events.size() - 1);
			entry.stamp   = $time;
			expected_events.push_back(entry);
		end
	endtask

	// sample driver: one transfer per accepting edge, random gap bursts between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_bus   <= '0;
			send_gap    = 0;
		end else begin
			if (item_valid && !item_stall)
				translate_sample(item_bus);
			// a stalled sample stays put until it is taken
			if (!(item_valid && item_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_samples.size() > 0 && !calm &&
						$urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 17);
					item_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					item_valid <= 1'b1;
					item_bus   <= pending_samples.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// event side stall: random bursts, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			sink_gap      = 0;
			hold_left     = 0;
			holds_served  = 0;
		end else begin
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				sink_gap = $urandom_range(0, 17);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// event monitor: every transfer is checked against the oldest expectation
	// that was queued at an earlier edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_events.size() == 0 || expected_events[0].stamp == $time) begin
				report_mismatch($sformatf("event with nothing expected %p", result_bus));
			end else begin
				wanted = expected_events[0].ev;
				expected_events.delete(0);
				compare_field("event_kind", 16'(result_bus.event_kind),
					16'(wanted.event_kind));
				compare_field("key_group", 16'(result_bus.key_group), 16'(wanted.key_group));
				compare_field("key_slot", 16'(result_bus.key_slot), 16'(wanted.key_slot));
				compare_field("pressed", 16'(result_bus.pressed), 16'(wanted.pressed));
				compare_field("axis_number", 16'(result_bus.axis_number),
					16'(wanted.axis_number));
				compare_field("axis_value", result_bus.axis_value, wanted.axis_value);
				compare_field("last", 16'(result_bus.last), 16'(wanted.last));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_sample(input logic [1:0] cmd, input logic [3:0] idx,
			input logic [15:0] value);
		item_t smp;
		smp.command = cmd;
		smp.index   = idx;
		smp.sample  = value;
		pending_samples.push_back(smp);
	endtask

	// mostly well-formed samples aimed at state changes, some noise
	task automatic queue_random(input int count);
		item_t smp;
		int    roll, dz, v;
		dz = int'(cur_dead_zone);
		repeat (count) begin
			roll        = $urandom_range(0, 99);
			smp.sample  = 16'($urandom);
			smp.index   = 4'($urandom);
			if (roll < 5) begin
				smp.command = CMD_UNUSED;
			end else if (roll < 30) begin
				smp.command = CMD_BUTTON;
				if ($urandom_range(0, 9) < 7)
					smp.sample = 16'($urandom_range(0, 1));
			end else if (roll < 55) begin
				smp.command = CMD_HAT;
				if ($urandom_range(0, 19) < 17)
					smp.index = 4'($urandom_range(0, 3));
				if ($urandom_range(0, 3) != 0) begin
					smp.sample[3:0] = HAT_SHAPES[$urandom_range(0, 8)];
					if ($urandom_range(0, 9) < 7)
						smp.sample[15:4] = '0;
				end
			end else begin
				smp.command = CMD_AXIS;
				if (!cur_analog_mode && $urandom_range(0, 4) != 0)
					smp.index = 4'($urandom_range(0, 7));
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = -32768;
					2: v = 32767;
					3: v = dz + int'($urandom_range(0, 2)) - 1;
					4: v = -(dz + int'($urandom_range(0, 2)) - 1);
					default: v = $signed(16'($urandom));
				endcase
				smp.sample = 16'(v);
			end
			pending_samples.push_back(smp);
		end
	endtask

	// block idle: all samples taken, all events out, plus margin
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || item_valid || expected_events.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [14:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(negedge clk);
		while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DEAD_ZONE)
			cur_dead_zone = data;
		else if (idx == REG_ANALOG_MODE)
			cur_analog_mode = data[0];
		@(negedge clk);
	endtask

	initial begin
		logic [14:0] zone;
		logic        mode;
		cur_dead_zone   = DEAD_ZONE_RESET;
		cur_analog_mode = 1'b0;
		button_held     = '0;
		dir_keys_held   = '0;
		foreach (hat_last[i])
			hat_last[i] = '0;
		foreach (analog_last[i])
			analog_last[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, digital mode at reset dead zone
		queue_sample(CMD_BUTTON, 4'd0, 16'h8000);      // any nonzero level is a press
		queue_sample(CMD_BUTTON, 4'd0, 16'h0100);      // still held, no transfer
		queue_sample(CMD_BUTTON, 4'd15, 16'd1);
		queue_sample(CMD_BUTTON, 4'd0, 16'd0);
		queue_sample(CMD_UNUSED, 4'd5, 16'd1);         // unused command is dropped
		queue_sample(CMD_HAT, 4'd0, 16'hFFF3);         // upper bits ignored, up then right
		queue_sample(CMD_HAT, 4'd0, 16'd6);            // two releases, then presses down then right
		queue_sample(CMD_HAT, 4'd3, 16'd12);
		queue_sample(CMD_HAT, 4'd3, 16'd9);
		queue_sample(CMD_HAT, 4'd3, 16'd5);            // opposite bits: release only
		queue_sample(CMD_HAT, 4'd3, 16'd15);           // stored, no keys
		queue_sample(CMD_HAT, 4'd7, 16'd1);            // hat out of range
		queue_sample(CMD_AXIS, 4'd0, 16'h8000);
		queue_sample(CMD_AXIS, 4'd0, 16'h7FFF);
		queue_sample(CMD_AXIS, 4'd0, 16'(DEAD_ZONE_RESET));  // on the threshold: neither
		queue_sample(CMD_AXIS, 4'd7, 16'(DEAD_ZONE_RESET + 1));
		queue_sample(CMD_AXIS, 4'd15, 16'h7FFF);       // no keys above axis 7
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		for (int p = 1; p < 8; p++) begin
			case (p)
				1: begin zone = 15'd0;     mode = 1'b1; end
				2: begin zone = 15'h7FFF;  mode = 1'b1; end
				3: begin zone = 15'h7FFF;  mode = 1'b0; end
				4: begin zone = 15'($urandom); mode = 1'b1; end
				5: begin zone = 15'd0;     mode = 1'b0; end
				6: begin zone = 15'($urandom_range(0, 8000)); mode = 1'b0; end
				default: begin zone = DEAD_ZONE_RESET; mode = 1'b1; end
			endcase
			write_register(REG_DEAD_ZONE, zone);
			write_register(REG_ANALOG_MODE, 15'(mode));
			if (p == 1) begin
				// long hold-off on the event side while samples keep coming
				hold_requests++;
				queue_sample(CMD_AXIS, 4'd7, 16'hFFFF);    // releases held key, then value
				queue_sample(CMD_AXIS, 4'd15, 16'h8000);
			end
			if (p == 2) begin
				queue_sample(CMD_AXIS, 4'd3, 16'h7FFF);    // equal to the threshold passes
				queue_sample(CMD_AXIS, 4'd3, 16'h8002);    // just under: reads as zero
				queue_sample(CMD_AXIS, 4'd3, 16'h8000);    // magnitude 32768 passes
			end
			// last phase runs without random idle gaps
			if (p == 7)
				calm = 1'b1;
			queue_random(RANDOM_PER_PHASE);
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d expected events never came",
				expected_events.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* joystick_event_translator.f */
sv/jet_pkg.sv
sv/jet_front.sv
sv/jet_queue.sv
sv/jet_back.sv
sv/joystick_event_translator.sv
sim/joystick_event_translator_tb.sv
